// ----- sv/rolling_window_mean_std_macros.svh -----
// Assertion macros for the rolling window mean and deviation block.
// Each macro expects signals named clk and arst_n in the module that uses it.
`ifndef ROLLING_WINDOW_MEAN_STD_MACROS_SVH
`define ROLLING_WINDOW_MEAN_STD_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RWMS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RWMS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/rwms_pkg.sv -----
// Shared constants and types for the rolling window mean and deviation block.
// No dependencies.
package rwms_pkg;

	localparam int SAMPLE_W       = 16;
	localparam int CFG_W          = 11;
	localparam int MEAN_W         = 24;
	localparam int STD_W          = 24;
	localparam int FRAC_W         = 8;
	localparam int WINDOW_MAX_DEF = 1024;
	localparam int LEN_RESET      = 64;

	// Default widths for the arithmetic units at the default window depth.
	localparam int PTR_W_DEF  = $clog2(WINDOW_MAX_DEF);
	localparam int LEN_W_DEF  = PTR_W_DEF + 1;
	localparam int SUM_W_DEF  = SAMPLE_W + PTR_W_DEF;
	localparam int DIV_W_DEF  = SUM_W_DEF + FRAC_W;
	localparam int RAD_W_DEF  = 2 * SUM_W_DEF;
	localparam int ROOT_W_DEF = (RAD_W_DEF + 2 * FRAC_W + 1) / 2;

	typedef struct packed {
		logic busy;
		logic rem_nz;
	} div_status_t;

endpackage

// ----- sv/rwms_div.sv -----
// Iterative restoring divider, one quotient bit per cycle.
// Depends on rwms_pkg.
module rwms_div import rwms_pkg::*; #(
	parameter int DIV_W = DIV_W_DEF,
	parameter int LEN_W = LEN_W_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] dividend,
	input  logic [LEN_W-1:0] divisor,
	output logic [DIV_W-1:0] quotient,
	output div_status_t      status
);

	localparam int CNT_W = $clog2(DIV_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0] q_q;
	logic [LEN_W-1:0] rem_q;
	logic [LEN_W:0]   rem_n;
	logic [LEN_W:0]   rem_sub;
	logic             ge;

	assign rem_n   = {rem_q, q_q[DIV_W-1]};
	assign rem_sub = rem_n - {1'b0, divisor};
	assign ge      = rem_n >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(DIV_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// The dividend shifts out at the top while quotient bits shift in below.
	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= dividend;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? rem_sub[LEN_W-1:0] : rem_n[LEN_W-1:0];
			q_q   <= {q_q[DIV_W-2:0], ge};
		end
	end

	assign quotient      = q_q;
	assign status.busy   = (cnt_q != '0);
	assign status.rem_nz = |rem_q;

endmodule

// ----- sv/rwms_isqrt.sv -----
// Iterative integer square root of (radicand << 2*FRAC_W), two radicand bits per cycle.
// Depends on rwms_pkg.
module rwms_isqrt import rwms_pkg::*; #(
	parameter int RAD_W  = RAD_W_DEF,
	parameter int ROOT_W = ROOT_W_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [RAD_W-1:0]  radicand,
	output logic [ROOT_W-1:0] root,
	output logic              busy
);

	localparam int X_W   = 2 * ROOT_W;
	localparam int CNT_W = $clog2(ROOT_W + 1);

	logic [CNT_W-1:0]  cnt_q;
	logic [X_W-1:0]    x_q;
	logic [ROOT_W+1:0] rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [ROOT_W+1:0] rem_n;
	logic [ROOT_W+1:0] trial;
	logic              ge;

	// Before the last step the partial root is narrower than ROOT_W, so the
	// remainder fits in ROOT_W bits when the next pair is shifted in.
	assign rem_n = {rem_q[ROOT_W-1:0], x_q[X_W-1 -: 2]};
	assign trial = {root_q, 2'b01};
	assign ge    = rem_n >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(ROOT_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= X_W'({radicand, {(2 * FRAC_W){1'b0}}});
			rem_q  <= '0;
			root_q <= '0;
		end else if (cnt_q != '0) begin
			x_q    <= {x_q[X_W-3:0], 2'b00};
			rem_q  <= ge ? (rem_n - trial) : rem_n;
			root_q <= {root_q[ROOT_W-2:0], ge};
		end
	end

	assign root = root_q;
	assign busy = (cnt_q != '0);

endmodule

// ----- sv/rolling_window_mean_std.sv -----
// Sliding-window mean and population standard deviation, 8 fractional bits.
// Depends on rwms_pkg, rwms_div, rwms_isqrt and the assertion macro header.
// An item that leaves the window short of full passes through OLD, SQR and ADD back to idle;
// an item with a result goes on through MLO, MHI, MSUM and VAR, waits in WAIT1 for the shared
// divider beside the square root, then in WAIT2 for the divider on the root and output stalls.
// Reset clears control and sums, sets window length min(64, WINDOW_MAX); delay line not cleared.
`include "rolling_window_mean_std_macros.svh"

module rolling_window_mean_std import rwms_pkg::*; #(
	parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_axis_tvalid,
	output logic                     s_axis_tready,
	input  logic [SAMPLE_W-1:0]      s_axis_tdata,  // [15:0] sample
	input  logic [0:0]               s_axis_tuser,  // [0] start_req
	output logic                     m_axis_tvalid,
	input  logic                     m_axis_tready,
	output logic [MEAN_W+STD_W-1:0]  m_axis_tdata,  // [23:0] mean, [47:24] std_dev
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_W-1:0]         cfg_data       // window_length
);

	localparam int PTR_W  = $clog2(WINDOW_MAX);
	localparam int LEN_W  = PTR_W + 1;
	localparam int SUM_W  = SAMPLE_W + PTR_W;
	localparam int SQ_W   = 2 * SAMPLE_W - 1 + PTR_W;
	localparam int V_W    = 2 * SUM_W;
	localparam int HALF   = (SQ_W + 1) / 2;
	localparam int HI_W   = SQ_W - HALF;
	localparam int MUL_W  = SUM_W;
	localparam int DIV_W  = SUM_W + FRAC_W;
	localparam int ROOT_W = (V_W + 2 * FRAC_W + 1) / 2;
	localparam int LEN_RST = (LEN_RESET > WINDOW_MAX) ? WINDOW_MAX : LEN_RESET;

	localparam logic [LEN_W-1:0] WM_C = LEN_W'(WINDOW_MAX);
	localparam logic [PTR_W-1:0] WP_LAST = PTR_W'(WINDOW_MAX - 1);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_OLD   = 4'd1;
	localparam logic [3:0] ST_SQR   = 4'd2;
	localparam logic [3:0] ST_ADD   = 4'd3;
	localparam logic [3:0] ST_MLO   = 4'd4;
	localparam logic [3:0] ST_MHI   = 4'd5;
	localparam logic [3:0] ST_MSUM  = 4'd6;
	localparam logic [3:0] ST_VAR   = 4'd7;
	localparam logic [3:0] ST_WAIT1 = 4'd8;
	localparam logic [3:0] ST_WAIT2 = 4'd9;

	logic [3:0]                 state_q;
	logic [LEN_W-1:0]           len_q;
	logic [LEN_W-1:0]           fill_q;
	logic [PTR_W-1:0]           wp_q;
	logic signed [SUM_W-1:0]    sum_q;
	logic [SQ_W-1:0]            sumsq_q;
	logic                       remove_q;
	logic signed [SAMPLE_W-1:0] s_q;
	logic signed [SAMPLE_W-1:0] rd_q;
	logic [V_W-1:0]             prod_q;
	logic [V_W-1:0]             a_q;
	logic [MEAN_W-1:0]          mean_q;
	logic                       out_valid_q;
	logic [MEAN_W-1:0]          mean_out_q;
	logic [STD_W-1:0]           std_out_q;

	logic [SAMPLE_W-1:0] mem [WINDOW_MAX];

	logic                 in_acc;
	logic                 cfg_acc;
	logic [LEN_W-1:0]     idx_tmp;
	logic [PTR_W-1:0]     old_idx;
	logic [LEN_W-1:0]     fill_next;
	logic [SAMPLE_W-1:0]  s_mag;
	logic [SAMPLE_W-1:0]  rd_mag;
	logic [SUM_W-1:0]     sum_mag;
	logic [MUL_W-1:0]     mul_a;
	logic [MUL_W-1:0]     mul_b;
	logic [V_W-1:0]       v_calc;
	logic [DIV_W:0]       q_up;
	logic [DIV_W:0]       mean_full;
	logic                 div_start;
	logic [DIV_W-1:0]     div_dividend;
	logic [DIV_W-1:0]     div_quot;
	div_status_t          div_st;
	logic                 sqrt_start;
	logic [ROOT_W-1:0]    sqrt_root;
	logic                 sqrt_busy;
	logic                 both_done;
	logic                 out_load;

	// A register write is taken only while idle and wins over a waiting sample.
	assign s_axis_tready = (state_q == ST_IDLE) && !cfg_valid;
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = (state_q == ST_IDLE);
	assign cfg_acc       = cfg_valid && cfg_ready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {std_out_q, mean_out_q};

	// Position of the sample that leaves the window, modulo the delay-line depth.
	always_comb begin
		idx_tmp = {1'b0, wp_q} + (WM_C - len_q);
		if (idx_tmp >= WM_C) begin
			idx_tmp = idx_tmp - WM_C;
		end
		old_idx = idx_tmp[PTR_W-1:0];
	end

	assign fill_next = remove_q ? len_q : (fill_q + 1'b1);
	assign s_mag     = s_q[SAMPLE_W-1] ? (~s_q + 1'b1) : s_q;
	assign rd_mag    = rd_q[SAMPLE_W-1] ? (~rd_q + 1'b1) : rd_q;
	assign sum_mag   = sum_q[SUM_W-1] ? (~sum_q + 1'b1) : sum_q;
	assign v_calc    = (a_q > prod_q) ? (a_q - prod_q) : '0;
	assign both_done = !div_st.busy && !sqrt_busy;
	assign out_load  = (state_q == ST_WAIT2) && !div_st.busy
		&& (!out_valid_q || m_axis_tready);

	// Operand selection for the shared multiplier.
	always_comb begin
		case (state_q)
			ST_OLD: begin
				mul_a = MUL_W'(rd_mag);
				mul_b = MUL_W'(rd_mag);
			end
			ST_SQR: begin
				mul_a = MUL_W'(s_mag);
				mul_b = MUL_W'(s_mag);
			end
			ST_MLO: begin
				mul_a = MUL_W'(len_q);
				mul_b = MUL_W'(sumsq_q[HALF-1:0]);
			end
			ST_MHI: begin
				mul_a = MUL_W'(len_q);
				mul_b = MUL_W'(sumsq_q[SQ_W-1 -: HI_W]);
			end
			ST_MSUM: begin
				mul_a = sum_mag;
				mul_b = sum_mag;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Floor division of a negative mean rounds the magnitude up when inexact.
	assign q_up      = {1'b0, div_quot} + (DIV_W + 1)'(div_st.rem_nz);
	assign mean_full = sum_q[SUM_W-1] ? (~q_up + 1'b1) : {1'b0, div_quot};

	assign sqrt_start   = (state_q == ST_VAR);
	assign div_start    = (state_q == ST_VAR) || ((state_q == ST_WAIT1) && both_done);
	assign div_dividend = (state_q == ST_VAR) ? {sum_mag, {FRAC_W{1'b0}}}
		: DIV_W'(sqrt_root);

	rwms_div #(
		.DIV_W (DIV_W),
		.LEN_W (LEN_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (len_q),
		.quotient (div_quot),
		.status   (div_st)
	);

	rwms_isqrt #(
		.RAD_W  (V_W),
		.ROOT_W (ROOT_W)
	) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (v_calc),
		.root     (sqrt_root),
		.busy     (sqrt_busy)
	);

	// Delay line: the leaving sample is read on acceptance, the new one written later.
	always_ff @(posedge clk) begin
		if (state_q == ST_SQR) begin
			mem[wp_q] <= s_q;
		end
		if (in_acc) begin
			rd_q <= mem[old_idx];
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (in_acc) begin
			s_q <= s_axis_tdata;
		end
		case (state_q)
			ST_MHI:   a_q <= prod_q;
			ST_MSUM:  a_q <= a_q + (prod_q << HALF);
			default:  a_q <= a_q;
		endcase
		if ((state_q == ST_WAIT1) && both_done) begin
			mean_q <= mean_full[MEAN_W-1:0];
		end
		if (out_load) begin
			mean_out_q <= mean_q;
			std_out_q  <= div_quot[STD_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			len_q       <= LEN_W'(LEN_RST);
			fill_q      <= '0;
			wp_q        <= '0;
			sum_q       <= '0;
			sumsq_q     <= '0;
			remove_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end

			if (cfg_acc) begin
				if (cfg_data == '0) begin
					len_q <= LEN_W'(1);
				end else if (32'(cfg_data) > WINDOW_MAX) begin
					len_q <= WM_C;
				end else begin
					len_q <= LEN_W'(cfg_data);
				end
				fill_q  <= '0;
				sum_q   <= '0;
				sumsq_q <= '0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						remove_q <= !s_axis_tuser[0] && (fill_q >= len_q);
						if (s_axis_tuser[0]) begin
							fill_q  <= '0;
							sum_q   <= '0;
							sumsq_q <= '0;
						end
						state_q <= ST_OLD;
					end
				end
				ST_OLD: begin
					state_q <= ST_SQR;
				end
				ST_SQR: begin
					if (remove_q) begin
						sum_q   <= sum_q - SUM_W'(rd_q);
						sumsq_q <= sumsq_q - prod_q[SQ_W-1:0];
					end
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					sum_q   <= sum_q + SUM_W'(s_q);
					sumsq_q <= sumsq_q + prod_q[SQ_W-1:0];
					fill_q  <= fill_next;
					wp_q    <= (wp_q == WP_LAST) ? '0 : (wp_q + 1'b1);
					state_q <= (fill_next == len_q) ? ST_MLO : ST_IDLE;
				end
				ST_MLO: begin
					state_q <= ST_MHI;
				end
				ST_MHI: begin
					state_q <= ST_MSUM;
				end
				ST_MSUM: begin
					state_q <= ST_VAR;
				end
				ST_VAR: begin
					state_q <= ST_WAIT1;
				end
				ST_WAIT1: begin
					if (both_done) begin
						state_q <= ST_WAIT2;
					end
				end
				ST_WAIT2: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`RWMS_ASSERT_NEXT(a_busy_after_accept, in_acc, !s_axis_tready, "input taken while busy")
	`RWMS_ASSERT_NOW(a_fill_bound, 1'b1, fill_q <= len_q, "fill count beyond window length")
	`RWMS_ASSERT_NOW(a_units_free, state_q == ST_VAR, both_done, "arithmetic unit restarted early")

endmodule
